// File: rtl/sgs_pkg.sv
// Shared types and constants for the segment substitution block.
// Transaction payload structs, generator table entry and pipeline tag.
// No dependencies.
package sgs_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned IndexW    = 4;
  localparam int unsigned CountW    = 5;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 5;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CFG_GEN_COUNT  = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_LEAVE_ORIG = 2'd1;

  // opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SUBST = 1'b1;

  typedef struct packed {
    logic                     opcode;
    logic [IndexW-1:0]        entry_index;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic                     is_final;
  } sgs_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_start_x;
    logic signed [CoordW-1:0] out_start_y;
    logic signed [CoordW-1:0] out_end_x;
    logic signed [CoordW-1:0] out_end_y;
    logic                     out_final;
    logic                     last_of_run;
  } sgs_out_t;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic                     is_final;
  } sgs_entry_t;

  // tag that travels with each result through the pipeline
  typedef struct packed {
    logic valid;
    logic orig;   // emit the input segment itself, marked final
    logic last;
  } sgs_tok_t;

endpackage

// File: rtl/sgs_gen_mem.sv
// Generator table: one write port, one synchronous (registered) read port.
// Depends on sgs_pkg for the entry type.
module sgs_gen_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  sgs_pkg::sgs_entry_t wdata_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output sgs_pkg::sgs_entry_t rdata_o
);

  sgs_pkg::sgs_entry_t mem_q [DEPTH];
  sgs_pkg::sgs_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/sgs_ctrl.sv
// Sequencer: walks the generator table one entry per cycle while adv_i is
// high, then the optional kept original, and tags each issued read. Depends on sgs_pkg.
module sgs_ctrl #(
  parameter int unsigned CW            = 5,
  parameter int unsigned AW            = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              start_i,
  input  logic [CW-1:0]     gen_n_i,
  input  logic              orig_i,
  input  logic              done_i,
  output logic              idle_o,
  output logic [AW-1:0]     rd_addr_o,
  output sgs_pkg::sgs_tok_t tok_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     gen_n_q, gen_n_d;
  logic              orig_q, orig_d;
  sgs_pkg::sgs_tok_t tok_q, tok_d;
  sgs_pkg::sgs_tok_t tok_iss;
  logic              is_orig;

  assign is_orig = (idx_q == gen_n_q);

  always_comb begin
    tok_iss = '0;
    if (state_q == ST_ISSUE) begin
      tok_iss.valid = 1'b1;
      tok_iss.orig  = is_orig;
      tok_iss.last  = is_orig || (!orig_q && (idx_q == gen_n_q - CW'(1)));
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    gen_n_d = gen_n_q;
    orig_d  = orig_q;
    tok_d   = tok_q;
    if (adv_i) begin
      tok_d = tok_iss;
    end
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_ISSUE;
          idx_d   = '0;
          gen_n_d = gen_n_i;
          orig_d  = orig_i;
        end
      end
      ST_ISSUE: begin
        if (adv_i) begin
          idx_d = idx_q + CW'(1);
          if (tok_iss.last) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (done_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      gen_n_q <= '0;
      orig_q  <= 1'b0;
      tok_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      gen_n_q <= gen_n_d;
      orig_q  <= orig_d;
      tok_q   <= tok_d;
    end
  end

  assign idle_o    = (state_q == ST_IDLE);
  assign rd_addr_o = idx_q[AW-1:0];
  assign tok_o     = tok_q;

endmodule

// File: rtl/sgs_map_pipe.sv
// Point mapping datapath: start + delta * p as complex multiply, with
// round-to-nearest (ties up), origin add and 32-bit saturation.
// Stage 2 multiplies, stage 3 sums; final step feeds the output register.
// Depends on sgs_pkg.
module sgs_map_pipe #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  sgs_pkg::sgs_tok_t                 tok_i,
  input  sgs_pkg::sgs_entry_t               gen_i,
  input  logic signed [sgs_pkg::CoordW:0]   dx_i,
  input  logic signed [sgs_pkg::CoordW:0]   dy_i,
  input  sgs_pkg::sgs_in_t                  item_i,
  output sgs_pkg::sgs_tok_t                 tok_o,
  output sgs_pkg::sgs_out_t                 res_o
);

  localparam int unsigned PW = 64;
  localparam int unsigned SW = 66;
  localparam logic signed [SW-1:0] Half   = SW'(1) << (FRACTION_BITS - 1);
  localparam logic signed [SW-1:0] SatMax = {{(SW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SW-1:0] SatMin = {{(SW-31){1'b1}}, 31'b0};

  // product order: for each point (a = start, b = end) dx*px, dy*py, dx*py, dy*px
  logic signed [PW-1:0] prod_q [8];
  sgs_pkg::sgs_tok_t    tok2_q, tok3_q;
  logic                 fin2_q, fin3_q;
  // sum order: ax, ay, bx, by
  logic signed [SW-1:0] sum_q [4];

  logic signed [SW-1:0]             shr  [4];
  logic signed [SW-1:0]             tot  [4];
  logic signed [sgs_pkg::CoordW-1:0] org [4];
  logic signed [sgs_pkg::CoordW-1:0] crd [4];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q[0] <= PW'(dx_i) * PW'(gen_i.start_x);
      prod_q[1] <= PW'(dy_i) * PW'(gen_i.start_y);
      prod_q[2] <= PW'(dx_i) * PW'(gen_i.start_y);
      prod_q[3] <= PW'(dy_i) * PW'(gen_i.start_x);
      prod_q[4] <= PW'(dx_i) * PW'(gen_i.end_x);
      prod_q[5] <= PW'(dy_i) * PW'(gen_i.end_y);
      prod_q[6] <= PW'(dx_i) * PW'(gen_i.end_y);
      prod_q[7] <= PW'(dy_i) * PW'(gen_i.end_x);
      fin2_q    <= gen_i.is_final;
      for (int k = 0; k < 2; k++) begin
        sum_q[2*k]   <= SW'(prod_q[4*k])   - SW'(prod_q[4*k+1]) + Half;
        sum_q[2*k+1] <= SW'(prod_q[4*k+2]) + SW'(prod_q[4*k+3]) + Half;
      end
      fin3_q <= fin2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok2_q <= '0;
      tok3_q <= '0;
    end else if (adv_i) begin
      tok2_q <= tok_i;
      tok3_q <= tok2_q;
    end
  end

  assign org[0] = item_i.start_x;
  assign org[1] = item_i.start_y;
  assign org[2] = item_i.start_x;
  assign org[3] = item_i.start_y;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      shr[k] = sum_q[k] >>> FRACTION_BITS;
      tot[k] = shr[k] + SW'(org[k]);
      if (tot[k] > SatMax) begin
        crd[k] = SatMax[sgs_pkg::CoordW-1:0];
      end else if (tot[k] < SatMin) begin
        crd[k] = SatMin[sgs_pkg::CoordW-1:0];
      end else begin
        crd[k] = tot[k][sgs_pkg::CoordW-1:0];
      end
    end
  end

  always_comb begin
    if (tok3_q.orig) begin
      res_o.out_start_x = item_i.start_x;
      res_o.out_start_y = item_i.start_y;
      res_o.out_end_x   = item_i.end_x;
      res_o.out_end_y   = item_i.end_y;
      res_o.out_final   = 1'b1;
    end else begin
      res_o.out_start_x = crd[0];
      res_o.out_start_y = crd[1];
      res_o.out_end_x   = crd[2];
      res_o.out_end_y   = crd[3];
      res_o.out_final   = fin3_q;
    end
    res_o.last_of_run = tok3_q.last;
  end

  assign tok_o = tok3_q;

endmodule

// File: rtl/segment_generator_substitution_top.sv
// Segment substitution stage. A substitute transaction emits N = replacements
// (+1 kept original) results; each passes the table read, multiply, sum and
// output registers, one per cycle while the output is not stalled, and the
// next input is taken once the run's last result enters the output register.
// Async active-low reset clears control and config (generator_count=1,
// leave_original=0), not the table.
module segment_generator_substitution_top #(
  parameter int unsigned MAX_GENERATOR = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  sgs_pkg::sgs_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output sgs_pkg::sgs_out_t                   out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sgs_pkg::CfgIndexW-1:0]       cfg_index_i,
  input  logic [sgs_pkg::CfgDataW-1:0]        cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_GENERATOR + 1);
  localparam int unsigned AW = (MAX_GENERATOR > 1) ? $clog2(MAX_GENERATOR) : 1;

  logic [sgs_pkg::CountW-1:0] gen_count_q;
  logic                       leave_q;

  sgs_pkg::sgs_in_t                item_q;
  logic signed [sgs_pkg::CoordW:0] dx_q, dy_q;

  logic              out_valid_q;
  sgs_pkg::sgs_out_t out_q;

  logic                adv;
  logic                idle;
  logic                in_acc;
  logic                load_we;
  logic                subst_acc;
  logic [CW-1:0]       cnt_sat;
  logic [CW-1:0]       gen_n;
  logic                orig;
  logic                start;
  logic                done;
  logic [AW-1:0]       rd_addr;
  sgs_pkg::sgs_tok_t   tok1, tok3;
  sgs_pkg::sgs_entry_t wentry, rentry;
  sgs_pkg::sgs_out_t   res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_count_q <= sgs_pkg::CountW'(1);
      leave_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sgs_pkg::CFG_GEN_COUNT:  gen_count_q <= cfg_data_i[sgs_pkg::CountW-1:0];
        sgs_pkg::CFG_LEAVE_ORIG: leave_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = idle;
  assign in_acc     = in_valid_i && in_ready_o;
  assign subst_acc  = in_acc && (in_data_i.opcode == sgs_pkg::OP_SUBST);
  assign load_we    = in_acc && (in_data_i.opcode == sgs_pkg::OP_LOAD) &&
                      (32'(in_data_i.entry_index) < MAX_GENERATOR);

  assign cnt_sat = (32'(gen_count_q) > MAX_GENERATOR) ? CW'(MAX_GENERATOR)
                                                      : CW'(gen_count_q);
  assign gen_n   = in_data_i.is_final ? '0 : cnt_sat;
  assign orig    = in_data_i.is_final || leave_q;
  assign start   = subst_acc && ((gen_n != '0) || orig);
  assign done    = adv && tok3.valid && tok3.last;

  // segment held for the whole run
  always_ff @(posedge clk_i) begin
    if (subst_acc) begin
      item_q <= in_data_i;
      dx_q   <= (sgs_pkg::CoordW + 1)'(in_data_i.end_x) -
                (sgs_pkg::CoordW + 1)'(in_data_i.start_x);
      dy_q   <= (sgs_pkg::CoordW + 1)'(in_data_i.end_y) -
                (sgs_pkg::CoordW + 1)'(in_data_i.start_y);
    end
  end

  assign wentry.start_x  = in_data_i.start_x;
  assign wentry.start_y  = in_data_i.start_y;
  assign wentry.end_x    = in_data_i.end_x;
  assign wentry.end_y    = in_data_i.end_y;
  assign wentry.is_final = in_data_i.is_final;

  sgs_gen_mem #(
    .DEPTH (MAX_GENERATOR),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (AW'(in_data_i.entry_index)),
    .wdata_i (wentry),
    .re_i    (adv),
    .raddr_i (rd_addr),
    .rdata_o (rentry)
  );

  sgs_ctrl #(
    .CW            (CW),
    .AW            (AW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .start_i   (start),
    .gen_n_i   (gen_n),
    .orig_i    (orig),
    .done_i    (done),
    .idle_o    (idle),
    .rd_addr_o (rd_addr),
    .tok_o     (tok1)
  );

  sgs_map_pipe #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_pipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .tok_i  (tok1),
    .gen_i  (rentry),
    .dx_i   (dx_q),
    .dy_i   (dy_q),
    .item_i (item_q),
    .tok_o  (tok3),
    .res_o  (res)
  );

  // output register decouples the result side from the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= tok3.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
